// ===== rtl/core/hse_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hse_pkg
// Shared sizes for the heap sort engine: element width, store depth and the
// widths of the address and count fields that follow from the depth.
// ----------------------------------------------------------------------------
package hse_pkg;

    // element width
    localparam int DATA_W   = 32;
    // number of elements the store holds
    localparam int CAPACITY = 64;
    // store address width
    localparam int ADDR_W   = $clog2(CAPACITY);
    // element count width, holds CAPACITY itself
    localparam int CNT_W    = ADDR_W + 1;

endpackage

// ===== rtl/core/heap_sort_engine_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// heap_sort_engine_unit
// Collects signed elements into a store until a transaction marked last,
// heap-sorts them in place (max-heap build, then root extraction with an
// iterative sift-down) and streams them out in ascending order.
// ----------------------------------------------------------------------------
//
//  channel  | handshake            | payload
//  ---------+----------------------+------------------------------
//  input    | start / busy         | value[31:0] signed, last
//  result   | result_valid strobe  | value_res[31:0], last_res, overflow
//
// A transaction without last is stored and busy stays low.
// Each sift-down loads through S_LOAD and S_LOADW, then inspects one level per
// S_CHILD/S_CMP pair (one more level than it descends), through the dual-read
// store and one comparator; a set of n elements takes n/2 build sift-downs and
// n-1 extraction sift-downs, then emits; results leave one per cycle, no receiver stall.
// Reset (rst_n low, asynchronous) empties the set; the store is not cleared.
// Elements beyond CAPACITY are dropped and flag every result of their set.
//
module heap_sort_engine_unit (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic signed [hse_pkg::DATA_W-1:0]  value,
    input  logic                               last,
    output logic                               result_valid,
    output logic signed [hse_pkg::DATA_W-1:0]  value_res,
    output logic                               last_res,
    output logic                               overflow
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_LOADW,
        S_CHILD,
        S_CMP,
        S_EMIT
    } state_t;

    // sequencer registers
    state_t                       state_reg,   state_next;
    logic [hse_pkg::CNT_W-1:0]    cnt_reg,     cnt_next;
    logic                         ovf_reg,     ovf_next;
    logic                         extract_reg, extract_next;
    logic [hse_pkg::ADDR_W-1:0]   k_reg,       k_next;
    logic [hse_pkg::ADDR_W-1:0]   end_reg,     end_next;
    logic [hse_pkg::ADDR_W-1:0]   node_reg,    node_next;
    logic [hse_pkg::ADDR_W-1:0]   idx_reg,     idx_next;
    logic signed [hse_pkg::DATA_W-1:0] x_reg,  x_next;
    logic                         strobe_reg,  strobe_next;
    logic                         rlast_reg,   rlast_next;
    logic                         rovf_reg,    rovf_next;

    // element store
    logic signed [hse_pkg::DATA_W-1:0] store_mem [hse_pkg::CAPACITY];
    logic signed [hse_pkg::DATA_W-1:0] rd_a_q, rd_b_q;
    logic [hse_pkg::ADDR_W-1:0]   rd_a_addr, rd_b_addr, wr_addr;
    logic                         wr_en;
    logic signed [hse_pkg::DATA_W-1:0] wr_data;

    // datapath helpers
    logic [hse_pkg::CNT_W:0]      lc_idx, rc_idx, size_ext;
    logic [hse_pkg::CNT_W-1:0]    size_cur, cnt_inc, half_cnt;
    logic                         room, lc_ok, rc_ok, take_r, move;
    logic signed [hse_pkg::DATA_W-1:0] cand_val;
    logic [hse_pkg::CNT_W:0]      cand_idx;

    assign busy         = (state_reg != S_IDLE);
    assign result_valid = strobe_reg;
    assign value_res    = rd_a_q;
    assign last_res     = rlast_reg;
    assign overflow     = rovf_reg;

    // child indexes and the shared compare
    assign lc_idx   = {1'b0, node_reg, 1'b1};
    assign rc_idx   = lc_idx + (hse_pkg::CNT_W + 1)'(1);
    assign size_cur = extract_reg ? {1'b0, end_reg} : cnt_reg;
    assign size_ext = {1'b0, size_cur};
    assign lc_ok    = (lc_idx < size_ext);
    assign rc_ok    = (rc_idx < size_ext);
    assign take_r   = rc_ok && (rd_b_q > rd_a_q);
    assign cand_val = take_r ? rd_b_q : rd_a_q;
    assign cand_idx = take_r ? rc_idx : lc_idx;
    assign move     = lc_ok && (cand_val > x_reg);

    assign room     = (cnt_reg < hse_pkg::CNT_W'(hse_pkg::CAPACITY));
    assign cnt_inc  = cnt_reg + hse_pkg::CNT_W'(1);
    assign half_cnt = cnt_next >> 1;

    // sequencer next state
    always_comb
    begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        ovf_next     = ovf_reg;
        extract_next = extract_reg;
        k_next       = k_reg;
        end_next     = end_reg;
        node_next    = node_reg;
        idx_next     = idx_reg;
        x_next       = x_reg;
        strobe_next  = 1'b0;
        rlast_next   = rlast_reg;
        rovf_next    = rovf_reg;
        rd_a_addr    = idx_reg;
        rd_b_addr    = '0;
        wr_en        = 1'b0;
        wr_addr      = node_reg;
        wr_data      = x_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    // store the element or mark the drop
                    if (room)
                    begin
                        wr_en    = 1'b1;
                        wr_addr  = cnt_reg[hse_pkg::ADDR_W-1:0];
                        wr_data  = value;
                        cnt_next = cnt_inc;
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                    if (last)
                    begin
                        idx_next     = '0;
                        extract_next = 1'b0;
                        if (cnt_next >= hse_pkg::CNT_W'(2))
                        begin
                            k_next     = hse_pkg::ADDR_W'(half_cnt - hse_pkg::CNT_W'(1));
                            node_next  = hse_pkg::ADDR_W'(half_cnt - hse_pkg::CNT_W'(1));
                            state_next = S_LOAD;
                        end
                        else
                        begin
                            state_next = S_EMIT;
                        end
                    end
                end
            end
            S_LOAD:
            begin
                // fetch the element to sift, and the root when extracting
                rd_a_addr  = extract_reg ? end_reg : node_reg;
                rd_b_addr  = '0;
                state_next = S_LOADW;
            end
            S_LOADW:
            begin
                x_next = rd_a_q;
                if (extract_reg)
                begin
                    wr_en   = 1'b1;
                    wr_addr = end_reg;
                    wr_data = rd_b_q;
                end
                state_next = S_CHILD;
            end
            S_CHILD:
            begin
                rd_a_addr  = lc_idx[hse_pkg::ADDR_W-1:0];
                rd_b_addr  = rc_idx[hse_pkg::ADDR_W-1:0];
                state_next = S_CMP;
            end
            S_CMP:
            begin
                wr_en   = 1'b1;
                wr_addr = node_reg;
                if (move)
                begin
                    // larger child moves up, hole moves down
                    wr_data    = cand_val;
                    node_next  = cand_idx[hse_pkg::ADDR_W-1:0];
                    state_next = S_CHILD;
                end
                else
                begin
                    wr_data = x_reg;
                    if (!extract_reg)
                    begin
                        if (k_reg == '0)
                        begin
                            extract_next = 1'b1;
                            end_next     = hse_pkg::ADDR_W'(cnt_reg - hse_pkg::CNT_W'(1));
                            node_next    = '0;
                        end
                        else
                        begin
                            k_next    = k_reg - hse_pkg::ADDR_W'(1);
                            node_next = k_reg - hse_pkg::ADDR_W'(1);
                        end
                        state_next = S_LOAD;
                    end
                    else if (end_reg == hse_pkg::ADDR_W'(1))
                    begin
                        idx_next   = '0;
                        state_next = S_EMIT;
                    end
                    else
                    begin
                        end_next   = end_reg - hse_pkg::ADDR_W'(1);
                        node_next  = '0;
                        state_next = S_LOAD;
                    end
                end
            end
            S_EMIT:
            begin
                // one read per cycle, result shows with the read data
                rd_a_addr   = idx_reg;
                if (cnt_reg != '0)
                begin
                    strobe_next = 1'b1;
                end
                rovf_next   = ovf_reg;
                rlast_next  = ({1'b0, idx_reg} + hse_pkg::CNT_W'(1) == cnt_reg);
                idx_next    = idx_reg + hse_pkg::ADDR_W'(1);
                if (rlast_next || (cnt_reg == '0))
                begin
                    cnt_next   = '0;
                    ovf_next   = 1'b0;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // sequencer state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            cnt_reg     <= '0;
            ovf_reg     <= 1'b0;
            extract_reg <= 1'b0;
            strobe_reg  <= 1'b0;
            rlast_reg   <= 1'b0;
            rovf_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            ovf_reg     <= ovf_next;
            extract_reg <= extract_next;
            strobe_reg  <= strobe_next;
            rlast_reg   <= rlast_next;
            rovf_reg    <= rovf_next;
        end
    end

    // payload and index registers
    always_ff @(posedge clk)
    begin
        k_reg    <= k_next;
        end_reg  <= end_next;
        node_reg <= node_next;
        idx_reg  <= idx_next;
        x_reg    <= x_next;
    end

    // element store, one write and two registered reads
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            store_mem[wr_addr] <= wr_data;
        end
        rd_a_q <= store_mem[rd_a_addr];
        rd_b_q <= store_mem[rd_b_addr];
    end

`ifndef SYNTH
    // a result only follows an emit cycle
    a_strobe_after_emit: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(state_reg == S_EMIT))
        else $error("result strobe without emit cycle");

    // a last result comes only once the sequencer is back in idle
    a_last_strobed: assert property (@(posedge clk) disable iff (!rst_n)
        last_res && result_valid |-> $past(state_reg == S_EMIT) && !busy)
        else $error("final result while sequencer still running");

    // the block only leaves idle on a start
    a_busy_on_start: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy) |-> $past(start))
        else $error("busy rose without a start");

    // element count never exceeds the store
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= hse_pkg::CNT_W'(hse_pkg::CAPACITY))
        else $error("element count beyond capacity");
`endif

endmodule

// ===== test/heap_sort_engine_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// heap_sort_engine_checker
// Watches the input and result channels of the heap sort engine. It keeps its
// own copy of the element store, heap-sorts each completed set, queues the
// sorted elements and compares every result strobe against the oldest one.
// ----------------------------------------------------------------------------
module heap_sort_engine_checker (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    input  logic                               busy,
    input  logic signed [hse_pkg::DATA_W-1:0]  value,
    input  logic                               last,
    input  logic                               result_valid,
    input  logic signed [hse_pkg::DATA_W-1:0]  value_res,
    input  logic                               last_res,
    input  logic                               overflow,
    output int                                 mismatches,
    output int                                 pending,
    output int                                 sets_sorted,
    output int                                 results_checked,
    output int                                 overflow_sets
);

    typedef struct {
        logic signed [hse_pkg::DATA_W-1:0] value;
        logic                              last;
        logic                              ovf;
    } sorted_elem_t;

    // sorted elements still to come out of the engine, oldest first
    sorted_elem_t                      sorted_q[$];

    // shadow of the engine's set under collection
    logic signed [hse_pkg::DATA_W-1:0] held [hse_pkg::CAPACITY];
    int                                held_count;
    logic                              dropped_seen;

    // one line per mismatch, and count it
    task automatic report_mismatch(input string what,
                                   input logic [hse_pkg::DATA_W-1:0] got,
                                   input logic [hse_pkg::DATA_W-1:0] want);
        $display("[%0t] MISMATCH %s: got 0x%08h, expected 0x%08h", $realtime, what, got, want);
        mismatches++;
    endtask

    // push the element at node down until no child is larger or both are absent
    function automatic void sink_node(input int size, input int node);
        int                                top;
        int                                lc;
        int                                rc;
        bit                                settled;
        logic signed [hse_pkg::DATA_W-1:0] tmp;
        settled = 1'b0;
        while (!settled)
        begin
            top = node;
            lc  = 2 * node + 1;
            rc  = 2 * node + 2;
            if (lc < size && held[lc] > held[top])
                top = lc;
            if (rc < size && held[rc] > held[top])
                top = rc;
            if (top == node)
            begin
                settled = 1'b1;
            end
            else
            begin
                tmp       = held[node];
                held[node] = held[top];
                held[top]  = tmp;
                node       = top;
            end
        end
    endfunction

    // in-place heap sort of the first n held elements, ascending
    function automatic void heap_order(input int n);
        logic signed [hse_pkg::DATA_W-1:0] tmp;
        if (n >= 2)
        begin
            for (int k = n / 2; k > 0; k--)
                sink_node(n, k - 1);
            for (int tail = n - 1; tail > 0; tail--)
            begin
                tmp        = held[0];
                held[0]    = held[tail];
                held[tail] = tmp;
                sink_node(tail, 0);
            end
        end
    endfunction

    // store one accepted transaction; a last one sorts and queues the whole set
    function automatic void take_element(input logic signed [hse_pkg::DATA_W-1:0] v,
                                         input logic l);
        sorted_elem_t e;
        if (held_count < hse_pkg::CAPACITY)
        begin
            held[held_count] = v;
            held_count++;
        end
        else
        begin
            dropped_seen = 1'b1;
        end
        if (l)
        begin
            heap_order(held_count);
            for (int k = 0; k < held_count; k++)
            begin
                e.value = held[k];
                e.last  = (k == held_count - 1);
                e.ovf   = dropped_seen;
                sorted_q.push_back(e);
            end
            sets_sorted++;
            if (dropped_seen)
                overflow_sets++;
            held_count   = 0;
            dropped_seen = 1'b0;
        end
    endfunction

    // sample both channels at each rising edge
    always @(posedge clk or negedge rst_n)
    begin : watch
        sorted_elem_t head;
        if (!rst_n)
        begin
            held_count   = 0;
            dropped_seen = 1'b0;
            sorted_q.delete();
            pending     <= 0;
        end
        else
        begin
            // result side first: it drains the previous set
            if (result_valid !== 1'b0)
            begin
                if (result_valid !== 1'b1)
                begin
                    report_mismatch("result_valid unknown", result_valid, 1'b0);
                end
                else if (sorted_q.size() == 0)
                begin
                    report_mismatch("result with nothing pending", value_res, '0);
                end
                else
                begin
                    head = sorted_q.pop_front();
                    if (value_res !== head.value)
                        report_mismatch("value_res", value_res, head.value);
                    if (last_res !== head.last)
                        report_mismatch("last_res", last_res, head.last);
                    if (overflow !== head.ovf)
                        report_mismatch("overflow", overflow, head.ovf);
                    results_checked++;
                end
            end
            // input transaction
            if (start === 1'b1 && busy === 1'b0)
                take_element(value, last);
            pending <= sorted_q.size();
        end
    end

endmodule

// ===== test/heap_sort_engine_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// heap_sort_engine_unit_tb
// Feeds the heap sort engine with directed sets (extreme values, duplicates,
// sorted and reversed orders, single and two-element sets) and then random
// sets of mixed sizes, including full and overflowing ones, under three
// sender idle profiles. A separate checker predicts and compares results.
// ----------------------------------------------------------------------------
module heap_sort_engine_unit_tb;

    localparam int TARGET_ITEMS = 380;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int DRAIN_CYCLES = 1200;

    logic                              clk          = 1'b0;
    logic                              rst_n        = 1'b0;
    logic                              start        = 1'b0;
    logic signed [hse_pkg::DATA_W-1:0] value        = '0;
    logic                              last         = 1'b0;
    logic                              busy;
    logic                              result_valid;
    logic signed [hse_pkg::DATA_W-1:0] value_res;
    logic                              last_res;
    logic                              overflow;

    int mismatches;
    int pending;
    int sets_sorted;
    int results_checked;
    int overflow_sets;

    int items_sent  = 0;
    int idle_pct    = 26;
    int cycle_count = 0;

    // directed sets, laid out back to back; a set ends where its last bit is set
    logic signed [hse_pkg::DATA_W-1:0] directed_vals [24];
    logic                              directed_last [24];

    // 2 ns clock
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    heap_sort_engine_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .value        (value),
        .last         (last),
        .result_valid (result_valid),
        .value_res    (value_res),
        .last_res     (last_res),
        .overflow     (overflow)
    );

    heap_sort_engine_checker chk (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .value           (value),
        .last            (last),
        .result_valid    (result_valid),
        .value_res       (value_res),
        .last_res        (last_res),
        .overflow        (overflow),
        .mismatches      (mismatches),
        .pending         (pending),
        .sets_sorted     (sets_sorted),
        .results_checked (results_checked),
        .overflow_sets   (overflow_sets)
    );

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("heap_sort_engine_unit verification failed");
            $finish;
        end
    end

    // random element: full range, extremes, or a narrow band for duplicates
    function automatic logic signed [hse_pkg::DATA_W-1:0] pick_value();
        int band;
        case ($urandom_range(0, 9))
            0:       return {1'b1, {(hse_pkg::DATA_W-1){1'b0}}};
            1:       return {1'b0, {(hse_pkg::DATA_W-1){1'b1}}};
            2:       return '0;
            3:       return '1;
            4, 5:
            begin
                band = $urandom_range(0, 8);
                return band - 4;
            end
            default: return $urandom;
        endcase
    endfunction

    // present one transaction, wait for acceptance, then maybe idle
    task automatic send_item(input logic signed [hse_pkg::DATA_W-1:0] v, input logic l);
        int gap;
        start <= 1'b1;
        value <= v;
        last  <= l;
        @(posedge clk);
        while (busy !== 1'b0)
            @(posedge clk);
        items_sent++;
        idle_pct = (items_sent < 127) ? 26 : (items_sent < 254) ? 73 : 0;
        gap = 0;
        while (gap < 20 && $urandom_range(0, 99) < idle_pct)
            gap++;
        if (gap > 0)
        begin
            // junk on the payload while start is low must be ignored
            start <= 1'b0;
            value <= $urandom;
            last  <= 1'($urandom_range(0, 1));
            repeat (gap) @(posedge clk);
        end
    endtask

    // one set of n random elements, the final one marked last
    task automatic send_set(input int n);
        for (int i = 0; i < n; i++)
            send_item(pick_value(), i == n - 1);
    endtask

    initial
    begin : stimulus
        int r;
        int set_size;

        // single minimum; extremes mixed; duplicates; ascending; descending; pair
        directed_vals = '{32'sh8000_0000,
                          32'sh7fff_ffff, 32'sh8000_0000, 0, -1, 1,
                          7, 7, -7, 7,
                          -3, -2, -1, 0, 1, 2,
                          32'sh7fff_ffff, 100, 0, -100, 32'sh8000_0001, 32'sh8000_0000,
                          2, 1};
        directed_last = '{1'b1,
                          1'b0, 1'b0, 1'b0, 1'b0, 1'b1,
                          1'b0, 1'b0, 1'b0, 1'b1,
                          1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1,
                          1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1,
                          1'b0, 1'b1};

        // reset once
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part
        for (int i = 0; i < 24; i++)
            send_item(directed_vals[i], directed_last[i]);

        // full store, then one dropped last, then several dropped
        send_set(hse_pkg::CAPACITY);
        send_set(hse_pkg::CAPACITY + 1);
        send_set(hse_pkg::CAPACITY + $urandom_range(2, 8));

        // random sets, mostly small, the final one trimmed to the item budget
        while (items_sent < TARGET_ITEMS)
        begin
            r = $urandom_range(0, 99);
            if (r < 65)
                set_size = $urandom_range(1, 8);
            else if (r < 88)
                set_size = $urandom_range(9, 32);
            else if (r < 97)
                set_size = $urandom_range(33, hse_pkg::CAPACITY);
            else
                set_size = $urandom_range(hse_pkg::CAPACITY + 1, hse_pkg::CAPACITY + 8);
            if (set_size > TARGET_ITEMS - items_sent)
                set_size = TARGET_ITEMS - items_sent;
            send_set(set_size);
        end

        // drain
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("%0d transactions sent in %0d sets, %0d of them with dropped elements",
                 items_sent, sets_sorted, overflow_sets);
        $display("%0d sorted results compared, %0d mismatches", results_checked, mismatches);
        if (mismatches == 0 && pending == 0)
            $display("heap_sort_engine_unit verification clean");
        else
            $display("heap_sort_engine_unit verification failed");
        $finish;
    end

endmodule
